// ----- src/dfp_pkg.sv -----
// dfp_pkg: shared types and constants for the decimal field parser
// character classes, result status codes, register map and the queue entry layout
// no dependencies
`timescale 1ns / 1ps

package dfp_pkg;

    // character classes produced by the front end
    typedef enum logic [1:0] {
        KIND_NUL   = 2'd0,
        KIND_BLANK = 2'd1,
        KIND_DIGIT = 2'd2,
        KIND_OTHER = 2'd3
    } char_kind_t;

    // result status codes, also used as the sticky error code
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_MISSING = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;
    localparam logic [1:0] STATUS_RANGE   = 2'd3;

    // register map, byte addresses
    localparam logic [2:0] ADDR_MAX_VALUE = 3'd0;

    localparam logic [15:0] MAX_VALUE_RESET = 16'd1440;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // one classified character as it travels through the queue
    typedef struct packed {
        char_kind_t  kind;
        logic [3:0]  digit;
    } char_entry_t;

endpackage

// ----- src/dfp_if.sv -----
// dfp_in_if / dfp_out_if: valid/ready channels of the decimal field parser
// depends on dfp_pkg for nothing but naming style; payload widths are fixed
`timescale 1ns / 1ps

interface dfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface dfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink (input valid, input status, input value, output ready);
endinterface

// ----- src/decimal_field_parser_unit.sv -----
// decimal_field_parser_unit: top level of the streaming decimal field parser
// depends on dfp_pkg, dfp_if, dfp_front, dfp_queue, dfp_back
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+------------------------------
//   in_ch     | in  | valid / ready      | char_code[7:0]
//   out_ch    | out | valid / ready      | status[1:0], value[15:0]
//   apb       | in  | psel / penable     | paddr[2:0], pwdata, prdata
//
// one character per cycle sustained while the queue has room; the back end's
// multiply-by-ten, add and compare against max_value sets the cycle. a nul's
// result passes through its queue slot and then the result register, which
// loads it only once the result slot is free.
// reset clears phase, accumulator, error, queue and result register at once.
// a stalled result only holds the back end on the next nul; other characters
// keep flowing until the queue of QUEUE_DEPTH entries fills.
`timescale 1ns / 1ps

module decimal_field_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    dfp_in_if.sink      in_ch,
    dfp_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dfp_pkg::*;

    logic [15:0]  max_value_reg;
    logic         push;
    logic         pop;
    logic         queue_full;
    logic         queue_nonempty;
    char_entry_t  front_entry;
    char_entry_t  head_entry;

    // configuration register
    assign pready = 1'b1;
    assign prdata = {16'd0, max_value_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= MAX_VALUE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_MAX_VALUE[2]))
        begin
            max_value_reg <= pwdata[15:0];
        end
    end

    // classify
    dfp_front u_front (
        .in_valid   (in_ch.valid),
        .char_code  (in_ch.char_code),
        .queue_full (queue_full),
        .in_ready   (in_ch.ready),
        .push       (push),
        .entry      (front_entry)
    );

    // decouple
    dfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_nonempty),
        .head       (head_entry)
    );

    // execute
    dfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_value   (max_value_reg),
        .entry_valid (queue_nonempty),
        .entry       (head_entry),
        .pop         (pop),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .status      (out_ch.status),
        .value       (out_ch.value)
    );

endmodule

// ----- src/dfp_front.sv -----
// dfp_front: classifies each incoming character into nul, blank, digit or other
// depends on dfp_pkg
`timescale 1ns / 1ps

module dfp_front (
    input  logic                 in_valid,
    input  logic [7:0]           char_code,
    input  logic                 queue_full,
    output logic                 in_ready,
    output logic                 push,
    output dfp_pkg::char_entry_t entry
);
    import dfp_pkg::*;

    logic is_blank;
    logic is_numeral;
    logic [7:0] digit_off;

    // whitespace set: space, tab, cr, lf, vt, ff
    assign is_blank = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB) ||
                      (char_code == CHAR_CR) || (char_code == CHAR_LF) ||
                      (char_code == CHAR_VT) || (char_code == CHAR_FF);
    assign is_numeral = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit_off = char_code - CHAR_ZERO;

    // class and digit value for the queue
    always_comb
    begin
        entry.digit = is_numeral ? digit_off[3:0] : 4'd0;
        if (char_code == CHAR_NUL)
        begin
            entry.kind = KIND_NUL;
        end
        else if (is_blank)
        begin
            entry.kind = KIND_BLANK;
        end
        else if (is_numeral)
        begin
            entry.kind = KIND_DIGIT;
        end
        else
        begin
            entry.kind = KIND_OTHER;
        end
    end

    // accept whenever the queue has room
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

endmodule

// ----- src/dfp_queue.sv -----
// dfp_queue: small fifo of classified characters between front and back end
// depends on dfp_pkg
`timescale 1ns / 1ps

module dfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dfp_pkg::char_entry_t push_entry,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output dfp_pkg::char_entry_t head
);
    import dfp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    char_entry_t   slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- src/dfp_back.sv -----
// dfp_back: phase tracking, decimal accumulate with range check, result register
// depends on dfp_pkg
`timescale 1ns / 1ps

module dfp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          max_value,
    input  logic                 entry_valid,
    input  dfp_pkg::char_entry_t entry,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [15:0]          value
);
    import dfp_pkg::*;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_BODY  = 2'd1,
        PH_TRAIL = 2'd2
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [1:0]  err_reg;
    logic [1:0]  err_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [15:0] value_reg;
    logic [15:0] value_next;

    logic        slot_free;
    logic [19:0] candidate;

    // result slot frees up when empty or being taken this cycle
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = entry_valid && ((entry.kind != KIND_NUL) || slot_free);

    // acc * 10 + digit, at most 20 bits since acc stays within 16
    assign candidate = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + {16'd0, entry.digit};

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            unique case (entry.kind)
                KIND_NUL:
                begin
                    // end of field: report and clear
                    out_valid_next = 1'b1;
                    value_next     = 16'd0;
                    if (phase_reg == PH_LEAD)
                    begin
                        status_next = STATUS_MISSING;
                    end
                    else if (err_reg != STATUS_OK)
                    begin
                        status_next = err_reg;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        value_next  = acc_reg;
                    end
                    phase_next = PH_LEAD;
                    acc_next   = 16'd0;
                    err_next   = STATUS_OK;
                end
                KIND_BLANK:
                begin
                    if (phase_reg != PH_LEAD)
                    begin
                        phase_next = PH_TRAIL;
                    end
                end
                default:
                begin
                    // first error sticks
                    if (err_reg == STATUS_OK)
                    begin
                        if (phase_reg == PH_TRAIL || entry.kind == KIND_OTHER)
                        begin
                            err_next = STATUS_INVALID;
                        end
                        else if (candidate > {4'd0, max_value})
                        begin
                            err_next = STATUS_RANGE;
                        end
                        else
                        begin
                            acc_next = candidate[15:0];
                        end
                    end
                    if (phase_reg == PH_LEAD)
                    begin
                        phase_next = PH_BODY;
                    end
                end
            endcase
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            acc_reg       <= 16'd0;
            err_reg       <= STATUS_OK;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_OK;
            value_reg     <= 16'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            value_reg     <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

endmodule

// ----- src/dfp_checker.sv -----
// dfp_checker: port-level assertions for decimal_field_parser_unit, with bind
// depends on dfp_pkg and decimal_field_parser_unit port names
`timescale 1ns / 1ps

module dfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_status,
    input logic [15:0] out_value,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    import dfp_pkg::*;

    // a pending result beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // stalled result payload holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_status) && $stable(out_value))
        else $error("result payload changed while stalled");

    // an ok result never exceeds the programmed maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == STATUS_OK) |-> (out_value <= prdata[15:0]))
        else $error("ok result above max_value");

    // a non-ok result carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != STATUS_OK) |-> (out_value == 16'd0))
        else $error("error result with nonzero value");

    // a register write reads back on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == ADDR_MAX_VALUE[2])
        |=> prdata[15:0] == $past(pwdata[15:0]))
        else $error("max_value write not reflected");

endmodule

bind decimal_field_parser_unit dfp_checker u_dfp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_value  (out_ch.value),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);
